>>> rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the button press classifier
// Holds the event codes, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package bpc_pkg;

   // Field widths.
   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CfgWidth   = 16;
   localparam int unsigned EventWidth = 2;
   localparam int unsigned IndexWidth = 2;

   // Press event codes.
   localparam logic [EventWidth-1:0] EV_NONE      = 2'd0;
   localparam logic [EventWidth-1:0] EV_SHORT     = 2'd1;
   localparam logic [EventWidth-1:0] EV_LONG      = 2'd2;
   localparam logic [EventWidth-1:0] EV_VERY_LONG = 2'd3;

   // Configuration register indexes.
   localparam logic [IndexWidth-1:0] REG_DEBOUNCE_TIME  = 2'd0;
   localparam logic [IndexWidth-1:0] REG_LONG_TIME      = 2'd1;
   localparam logic [IndexWidth-1:0] REG_VERY_LONG_TIME = 2'd2;

   // Configuration reset values.
   localparam logic [CfgWidth-1:0] DEBOUNCE_TIME_RESET  = 16'd30;
   localparam logic [CfgWidth-1:0] LONG_TIME_RESET      = 16'd1000;
   localparam logic [CfgWidth-1:0] VERY_LONG_TIME_RESET = 16'd3000;

   // Thresholds handed from the register block to the classifier engine.
   typedef struct packed {
      logic [CfgWidth-1:0] debounce_time;
      logic [CfgWidth-1:0] long_time;
      logic [CfgWidth-1:0] very_long_time;
   } cfg_type;

endpackage

>>> rtl/bpc_req_if.sv
// ----------------------------------------------------------------------------
// bpc_req_if: poll channel
// Carries one poll transaction: timestamp and raw pressed level.
// ----------------------------------------------------------------------------
interface bpc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] time_ms;
   logic        raw_level;

   modport source (output valid, output time_ms, output raw_level, input ready);
   modport sink (input valid, input time_ms, input raw_level, output ready);
endinterface

>>> rtl/bpc_rsp_if.sv
// ----------------------------------------------------------------------------
// bpc_rsp_if: event channel
// Carries one result transaction: the classified press event.
// ----------------------------------------------------------------------------
interface bpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] press_event;

   modport source (output valid, output press_event, input ready);
   modport sink (input valid, input press_event, output ready);
endinterface

>>> rtl/bpc_csr.sv
// ----------------------------------------------------------------------------
// bpc_csr: configuration registers
// Three 16-bit threshold registers; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module bpc_csr
   import bpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]   csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_DEBOUNCE_TIME:  cfg_in.debounce_time  = csr_wdata;
            REG_LONG_TIME:      cfg_in.long_time      = csr_wdata;
            REG_VERY_LONG_TIME: cfg_in.very_long_time = csr_wdata;
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time  <= DEBOUNCE_TIME_RESET;
         cfg_ff.long_time      <= LONG_TIME_RESET;
         cfg_ff.very_long_time <= VERY_LONG_TIME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/bpc_engine.sv
// ----------------------------------------------------------------------------
// bpc_engine: debounce and press classification
// Holds the button state and computes one event per poll combinationally.
// ----------------------------------------------------------------------------
module bpc_engine
   import bpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  step,
   input  logic [TimeWidth-1:0]  time_ms,
   input  logic                  raw_level,
   output logic [EventWidth-1:0] press_event
);

   logic                 held_ff, held_in;
   logic                 last_raw_ff, last_raw_in;
   logic [TimeWidth-1:0] edge_time_ff, edge_time_in;
   logic [TimeWidth-1:0] press_start_ff, press_start_in;
   logic                 very_long_sent_ff, very_long_sent_in;

   logic [TimeWidth-1:0] since_edge;
   logic [TimeWidth-1:0] duration;
   logic                 stable;
   logic [EventWidth-1:0] event_code;

   // A raw change restarts the stability window in this same poll.
   always_comb begin
      last_raw_in  = raw_level;
      edge_time_in = (raw_level != last_raw_ff) ? time_ms : edge_time_ff;
      since_edge   = time_ms - edge_time_in;
      duration     = time_ms - press_start_ff;
      stable       = since_edge >= TimeWidth'(cfg.debounce_time);
   end

   // Press, hold and release decisions.
   always_comb begin
      held_in           = held_ff;
      press_start_in    = press_start_ff;
      very_long_sent_in = very_long_sent_ff;
      event_code        = EV_NONE;
      if (stable && raw_level && !held_ff) begin
         held_in           = 1'b1;
         press_start_in    = time_ms;
         very_long_sent_in = 1'b0;
      end else if (held_ff && raw_level) begin
         if (!very_long_sent_ff && (duration >= TimeWidth'(cfg.very_long_time))) begin
            very_long_sent_in = 1'b1;
            event_code        = EV_VERY_LONG;
         end
      end else if (stable && !raw_level && held_ff) begin
         held_in = 1'b0;
         if (very_long_sent_ff) begin
            event_code = EV_NONE;
         end else if (duration >= TimeWidth'(cfg.long_time)) begin
            event_code = EV_LONG;
         end else if (duration >= TimeWidth'(cfg.debounce_time)) begin
            event_code = EV_SHORT;
         end
      end
   end

   // State advances only when a poll transaction is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff           <= 1'b0;
         last_raw_ff       <= 1'b0;
         edge_time_ff      <= '0;
         press_start_ff    <= '0;
         very_long_sent_ff <= 1'b0;
      end else if (step) begin
         held_ff           <= held_in;
         last_raw_ff       <= last_raw_in;
         edge_time_ff      <= edge_time_in;
         press_start_ff    <= press_start_in;
         very_long_sent_ff <= very_long_sent_in;
      end
   end

   assign press_event = event_code;

   // A very-long event marks the press so it cannot fire again.
   a_very_long_marks: assert property (@(posedge clock) disable iff (reset)
      (step && event_code == EV_VERY_LONG) |=> very_long_sent_ff)
      else $error("very-long event did not set the sent flag");

   // A short or long event ends the press.
   a_release_clears_held: assert property (@(posedge clock) disable iff (reset)
      (step && (event_code == EV_SHORT || event_code == EV_LONG)) |=> !held_ff)
      else $error("release event left the button held");

   // Without an accepted press there is nothing to report.
   a_idle_no_event: assert property (@(posedge clock) disable iff (reset)
      !held_ff |-> (event_code == EV_NONE))
      else $error("event reported while the button was not held");

endmodule

>>> rtl/button_press_classifier.sv
// Path: a poll transaction is captured in the input register when accepted and
// is classified into the result register once that register is free or draining.
// Throughput: one poll per cycle while the event channel is not stalled; the
// engine updates its state once per processed poll.
// Reset: synchronous, active high; thresholds return to 30, 1000 and 3000 ms
// and all button state clears.
// ----------------------------------------------------------------------------
// button_press_classifier: debounced button press classifier
// Input register, classification engine and result register.
// ----------------------------------------------------------------------------
module button_press_classifier
   import bpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bpc_req_if.sink               req,
   bpc_rsp_if.source             rsp,
   input  logic                  csr_write_en,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]   csr_wdata
);

   cfg_type cfg;

   logic                  in_valid_ff, in_valid_in;
   logic [TimeWidth-1:0]  in_time_ff;
   logic                  in_raw_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [EventWidth-1:0] rsp_event_ff;
   logic [EventWidth-1:0] engine_event;
   logic                  advance;
   logic                  req_take;

   bpc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // The input stage moves on when the result register is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_take  = req.valid && req.ready;

   bpc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .step        (advance),
      .time_ms     (in_time_ff),
      .raw_level   (in_raw_ff),
      .press_event (engine_event)
   );

   // Handshake control for both stages.
   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? 1'b1 : ((rsp_valid_ff && rsp.ready) ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_time_ff <= req.time_ms;
         in_raw_ff  <= req.raw_level;
      end
      if (advance) begin
         rsp_event_ff <= engine_event;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.press_event = rsp_event_ff;

   // A stalled result stays in the result register.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> rsp_valid_ff)
      else $error("stalled result was lost");

   // An empty input stage always takes a new transaction.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req.ready)
      else $error("input stage empty but not ready");

   // Every processed poll produces a result in the next cycle.
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed poll produced no result");

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the button press classifier
// Drives timestamped polls through the poll channel and checks every press
// event against a cycle-free model of the debounce and press timing. A short
// table of hand-written polls comes first. Random press gestures with contact
// bounce and noise follow, under several threshold settings, with random
// idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import bpc_pkg::*;

   localparam int unsigned PhaseCount     = 6;
   localparam int unsigned PhasePolls     = 320;
   localparam int unsigned IdleMax        = 5;
   localparam int unsigned LongHoldCycles = 300;
   localparam int unsigned SettleCycles   = 8;
   localparam int unsigned RunLimitCycles = 200000;
   localparam int unsigned DirectedCount  = 22;

   // Index past the end of the register list; writes to it are dropped.
   localparam logic [IndexWidth-1:0] REG_UNUSED = 2'd3;

   // One row of the hand-written poll table. When known is set, the event is
   // taken from the row; otherwise it comes from the press model.
   typedef struct packed {
      logic [TimeWidth-1:0]  time_ms;
      logic                  raw_level;
      logic                  known;
      logic [EventWidth-1:0] press_event;
   } poll_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [IndexWidth-1:0] csr_index;
   logic [CfgWidth-1:0]   csr_wdata;

   bpc_req_if poll_if ();
   bpc_rsp_if event_if ();

   button_press_classifier u_top (
      .clock        (clock),
      .reset        (reset),
      .req          (poll_if),
      .rsp          (event_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Threshold copies and button state of the press model.
   logic [CfgWidth-1:0]   th_debounce  = DEBOUNCE_TIME_RESET;
   logic [CfgWidth-1:0]   th_long      = LONG_TIME_RESET;
   logic [CfgWidth-1:0]   th_very_long = VERY_LONG_TIME_RESET;
   logic                  btn_held       = 1'b0;
   logic                  btn_last_raw   = 1'b0;
   logic                  btn_vlong_sent = 1'b0;
   logic [TimeWidth-1:0]  btn_edge_time   = '0;
   logic [TimeWidth-1:0]  btn_press_start = '0;

   // Events still owed by the block, oldest first.
   logic [EventWidth-1:0] expected_events [$];

   int unsigned    mismatch_count = 0;
   int unsigned    polls_in_phase = 0;
   logic [TimeWidth-1:0] now_ms = '0;
   bit             no_idle      = 1'b0;
   bit             hold_pending = 1'b0;

   // Hand-written polls at the reset thresholds of 30, 1000 and 3000 ms.
   poll_row_type directed_polls [DirectedCount] = '{
      '{32'd0,          1'b0, 1'b1, EV_NONE},      // idle after reset
      '{32'd5,          1'b1, 1'b1, EV_NONE},      // raw press, not yet stable
      '{32'd35,         1'b1, 1'b1, EV_NONE},      // stable: press accepted
      '{32'd100,        1'b0, 1'b1, EV_NONE},      // release still bouncing
      '{32'd129,        1'b0, 1'b0, EV_NONE},      // one ms short of stable
      '{32'd130,        1'b0, 1'b1, EV_SHORT},     // stable release, 95 ms held
      '{32'd200,        1'b1, 1'b0, EV_NONE},
      '{32'd230,        1'b1, 1'b0, EV_NONE},
      '{32'd1240,       1'b0, 1'b0, EV_NONE},
      '{32'd1270,       1'b0, 1'b1, EV_LONG},      // 1040 ms held
      '{32'd2000,       1'b1, 1'b0, EV_NONE},
      '{32'd2030,       1'b1, 1'b0, EV_NONE},
      '{32'd5029,       1'b1, 1'b1, EV_NONE},      // one ms before very long
      '{32'd5030,       1'b1, 1'b1, EV_VERY_LONG}, // very long fires once
      '{32'd6000,       1'b1, 1'b1, EV_NONE},
      '{32'd6100,       1'b0, 1'b0, EV_NONE},
      '{32'd6130,       1'b0, 1'b1, EV_NONE},      // release after very long
      '{32'hFFFF_FFF0,  1'b1, 1'b0, EV_NONE},      // press across the wrap
      '{32'hFFFF_FFFF,  1'b1, 1'b0, EV_NONE},
      '{32'h0000_000E,  1'b1, 1'b0, EV_NONE},
      '{32'h0000_0020,  1'b0, 1'b0, EV_NONE},
      '{32'h0000_003E,  1'b0, 1'b0, EV_NONE}
   };

   // Press model: one poll in, one event out. Time differences wrap at 32 bits.
   function automatic logic [EventWidth-1:0] classify_poll(
      input logic [TimeWidth-1:0] now,
      input logic                 raw
   );
      logic [TimeWidth-1:0]  since_edge;
      logic [TimeWidth-1:0]  held_for;
      logic                  stable;
      logic [EventWidth-1:0] ev;
      ev = EV_NONE;
      if (raw != btn_last_raw) begin
         btn_last_raw  = raw;
         btn_edge_time = now;
      end
      since_edge = now - btn_edge_time;
      held_for   = now - btn_press_start;
      stable     = since_edge >= TimeWidth'(th_debounce);
      if (stable && raw && !btn_held) begin
         btn_held        = 1'b1;
         btn_press_start = now;
         btn_vlong_sent  = 1'b0;
      end else if (btn_held && raw) begin
         if (!btn_vlong_sent && held_for >= TimeWidth'(th_very_long)) begin
            btn_vlong_sent = 1'b1;
            ev = EV_VERY_LONG;
         end
      end else if (stable && !raw && btn_held) begin
         btn_held = 1'b0;
         if (btn_vlong_sent) begin
            ev = EV_NONE;
         end else if (held_for >= TimeWidth'(th_long)) begin
            ev = EV_LONG;
         end else if (held_for >= TimeWidth'(th_debounce)) begin
            ev = EV_SHORT;
         end
      end
      return ev;
   endfunction

   // Offer one poll after a random gap and wait for the transaction.
   task automatic send_poll(
      input logic [TimeWidth-1:0]  t,
      input logic                  raw,
      input logic                  known,
      input logic [EventWidth-1:0] known_ev
   );
      int unsigned           gap;
      logic [EventWidth-1:0] ev;
      gap = no_idle ? 0 : $urandom_range(0, IdleMax);
      @(negedge clock);
      if (gap > 0) begin
         poll_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      poll_if.valid     <= 1'b1;
      poll_if.time_ms   <= t;
      poll_if.raw_level <= raw;
      @(posedge clock);
      while (!poll_if.ready) @(posedge clock);
      ev = classify_poll(t, raw);
      expected_events.push_back(known ? known_ev : ev);
      polls_in_phase++;
   endtask

   // Hold one raw level for at least span ms, polling at random steps.
   task automatic send_level(input logic raw, input int unsigned span);
      int unsigned elapsed;
      int unsigned step;
      elapsed = 0;
      do begin
         step    = $urandom_range(0, span / 4 + 1);
         now_ms += step;
         elapsed += step;
         send_poll(now_ms, raw, 1'b0, EV_NONE);
      end while (elapsed < span);
   endtask

   // One press and release with contact bounce, or a burst of noise.
   task automatic press_gesture();
      int unsigned d;
      int unsigned l;
      int unsigned v;
      int unsigned bounce;
      int unsigned hold;
      int unsigned gap_ms;
      int          i;
      d = 32'(th_debounce);
      l = 32'(th_long);
      v = 32'(th_very_long);
      no_idle = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
         // Noise: time jumps anywhere and the level is random.
         repeat ($urandom_range(1, 4)) begin
            now_ms = $urandom;
            send_poll(now_ms, 1'($urandom_range(0, 1)), 1'b0, EV_NONE);
         end
      end else begin
         // Bounce ahead of the press.
         bounce = $urandom_range(0, 3);
         for (i = 0; i < bounce; i++) begin
            now_ms += $urandom_range(0, d / 2 + 1);
            send_poll(now_ms, ~i[0], 1'b0, EV_NONE);
         end
         // Hold time aimed at each class of press.
         case ($urandom_range(0, 4))
            0: hold = $urandom_range(0, d);
            1: hold = d + $urandom_range(0, (l > d) ? l - d : 0);
            2: hold = l + $urandom_range(0, (v > l) ? v - l : 0);
            3: hold = v + $urandom_range(0, v / 2 + 100);
            default: hold = $urandom_range(0, 4 * v + 100);
         endcase
         send_level(1'b1, hold);
         // Bounce on release, then a release that may be cut short.
         bounce = $urandom_range(0, 3);
         for (i = 0; i < bounce; i++) begin
            now_ms += $urandom_range(0, d / 2 + 1);
            send_poll(now_ms, i[0], 1'b0, EV_NONE);
         end
         gap_ms = ($urandom_range(0, 3) == 0) ? $urandom_range(0, d)
                                               : d + $urandom_range(0, d + 20);
         send_level(1'b0, gap_ms);
      end
   endtask

   // Stop offering polls and wait for every owed event.
   task automatic drain_events();
      @(negedge clock);
      poll_if.valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Drive one register write; the caller lowers the write enable afterwards.
   task automatic write_reg(input logic [IndexWidth-1:0] idx,
                            input logic [CfgWidth-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      case (idx)
         REG_DEBOUNCE_TIME:  th_debounce  = value;
         REG_LONG_TIME:      th_long      = value;
         REG_VERY_LONG_TIME: th_very_long = value;
         default: ;
      endcase
   endtask

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit.
   initial begin
      #(2 * RunLimitCycles);
      $display("Simulation FAILED");
      $finish;
   end

   // Event receiver: random stalls, one long hold on request, and checking.
   initial begin
      int unsigned           stall;
      logic [EventWidth-1:0] want;
      event_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            event_if.ready <= 1'b0;
            repeat (LongHoldCycles) @(negedge clock);
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, IdleMax);
            if (stall > 0) begin
               event_if.ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         event_if.ready <= 1'b1;
         @(posedge clock);
         while (!event_if.valid) @(posedge clock);
         if (expected_events.size() == 0) begin
            $error("press_event: expected none, actual %0d", event_if.press_event);
            mismatch_count++;
         end else begin
            want = expected_events.pop_front();
            if (event_if.press_event !== want) begin
               $error("press_event: expected %0d, actual %0d",
                      want, event_if.press_event);
               mismatch_count++;
            end
         end
      end
   end

   // Main sequence: reset, hand-written polls, then random phases.
   initial begin
      logic [CfgWidth-1:0] phase_cfg [PhaseCount][3];
      bit                  hold_issued;
      int                  p;
      int                  r;
      reset             = 1'b1;
      csr_write_en      = 1'b0;
      csr_index         = REG_DEBOUNCE_TIME;
      csr_wdata         = '0;
      poll_if.valid     = 1'b0;
      poll_if.time_ms   = '0;
      poll_if.raw_level = 1'b0;

      // Threshold settings: reset values, all zero, all maximum, tiny, random.
      phase_cfg[0] = '{DEBOUNCE_TIME_RESET, LONG_TIME_RESET, VERY_LONG_TIME_RESET};
      phase_cfg[1] = '{16'd0, 16'd0, 16'd0};
      phase_cfg[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
      phase_cfg[3] = '{16'd1, 16'd2, 16'd3};
      phase_cfg[4] = '{16'($urandom), 16'($urandom), 16'($urandom)};
      phase_cfg[5] = '{16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                       16'($urandom_range(0, 200))};

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < DirectedCount; r++) begin
         send_poll(directed_polls[r].time_ms, directed_polls[r].raw_level,
                   directed_polls[r].known, directed_polls[r].press_event);
      end
      now_ms = directed_polls[DirectedCount-1].time_ms;

      for (p = 0; p < PhaseCount; p++) begin
         // Reprogram the thresholds only with the block idle.
         drain_events();
         write_reg(REG_DEBOUNCE_TIME,  phase_cfg[p][0]);
         write_reg(REG_LONG_TIME,      phase_cfg[p][1]);
         write_reg(REG_VERY_LONG_TIME, phase_cfg[p][2]);
         if (p == 4) begin
            write_reg(REG_UNUSED, 16'($urandom));
         end
         @(negedge clock);
         csr_write_en <= 1'b0;

         polls_in_phase = 0;
         hold_issued    = 1'b0;
         while (polls_in_phase < PhasePolls) begin
            // Odd phases hold the receiver off so the poll channel backs up.
            if (p % 2 == 1 && !hold_issued && polls_in_phase >= 60) begin
               hold_pending = 1'b1;
               hold_issued  = 1'b1;
            end
            press_gesture();
         end
      end

      no_idle = 1'b0;
      drain_events();
      if (mismatch_count == 0 && expected_events.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
